// ----- rtl/arpc_pkg.sv -----
// arp cache resolver package: payload types, register indexes, control types
`timescale 1ns / 1ps

package arpc_pkg;

    localparam int CACHE_ENTRIES_DEF = 8;

    localparam int IP_W  = 32;
    localparam int MAC_W = 48;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GATEWAY_IP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBNET_MASK = 2'd2;

    localparam logic [IP_W-1:0] OWN_IP_RST      = 32'd167772687;
    localparam logic [IP_W-1:0] GATEWAY_IP_RST  = 32'd167772674;
    localparam logic [IP_W-1:0] SUBNET_MASK_RST = 32'd4294967040;

    localparam logic CMD_LEARN   = 1'b0;
    localparam logic CMD_RESOLVE = 1'b1;

    typedef struct packed {
        logic              command;
        logic [IP_W-1:0]   ip_addr;
        logic [MAC_W-1:0]  mac_addr;
    } t_in_item;

    typedef struct packed {
        logic              hit;
        logic [MAC_W-1:0]  resolved_mac;
        logic              send_request;
        logic [IP_W-1:0]   target_ip;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan_issue;
        logic write_entry;
        logic out_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_resolve;
        logic scan_last;
        logic out_free;
    } t_dp_stat;

endpackage

// ----- rtl/arpc_ctrl.sv -----
// arp cache resolver controller: sequences load, scan, write and result
`timescale 1ns / 1ps

module arpc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  arpc_pkg::t_dp_stat i_stat,
    output arpc_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_LAST   = 5'b00100,
        S_WRITE  = 5'b01000,
        S_RESULT = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state           = r_state;
        o_cmd             = '0;
        o_in_ready        = 1'b0;
        unique case (r_state)
            // no beat is taken while reset is held
            S_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_issue = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_LAST;
                end
            end
            // last compare lands here
            S_LAST: begin
                n_state = i_stat.is_resolve ? S_RESULT : S_WRITE;
            end
            S_WRITE: begin
                o_cmd.write_entry = 1'b1;
                n_state           = S_IDLE;
            end
            S_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/arpc_datapath.sv -----
// arp cache resolver datapath: config, entry store, scan compare, output register
`timescale 1ns / 1ps

module arpc_datapath #(
    parameter int CACHE_ENTRIES = arpc_pkg::CACHE_ENTRIES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [arpc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [arpc_pkg::IP_W-1:0]           i_cfg_data,
    input  arpc_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output arpc_pkg::t_out_item                 o_out_data,
    input  arpc_pkg::t_dp_cmd                   i_cmd,
    output arpc_pkg::t_dp_stat                  o_stat
);

    localparam int IDX_W   = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int CNT_W   = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int ENTRY_W = arpc_pkg::IP_W + arpc_pkg::MAC_W;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(CACHE_ENTRIES - 1);

    // configuration
    logic [arpc_pkg::IP_W-1:0] r_own_ip, r_gateway_ip, r_subnet_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_ip      <= arpc_pkg::OWN_IP_RST;
            r_gateway_ip  <= arpc_pkg::GATEWAY_IP_RST;
            r_subnet_mask <= arpc_pkg::SUBNET_MASK_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                arpc_pkg::CFG_OWN_IP:      r_own_ip      <= i_cfg_data;
                arpc_pkg::CFG_GATEWAY_IP:  r_gateway_ip  <= i_cfg_data;
                arpc_pkg::CFG_SUBNET_MASK: r_subnet_mask <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // captured item; target chosen at load
    logic                       r_command;
    logic [arpc_pkg::IP_W-1:0]  r_target;
    logic [arpc_pkg::MAC_W-1:0] r_mac;
    logic                       off_link;

    assign off_link = ((i_in_data.ip_addr ^ r_own_ip) & r_subnet_mask) != '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_command <= i_in_data.command;
            r_mac     <= i_in_data.mac_addr;
            if (i_in_data.command == arpc_pkg::CMD_RESOLVE && off_link) begin
                r_target <= r_gateway_ip;
            end else begin
                r_target <= i_in_data.ip_addr;
            end
        end
    end

    // scan counter and read stage
    logic [CNT_W-1:0]             r_cnt;
    logic [IDX_W-1:0]             rd_idx;
    logic                         r_pipe_vld;
    logic [IDX_W-1:0]             r_pipe_idx;
    logic                         r_pipe_ent_vld;
    logic [ENTRY_W-1:0]           r_rd_data;
    logic [CACHE_ENTRIES-1:0]     r_valid;
    logic [ENTRY_W-1:0]           mem [CACHE_ENTRIES];

    assign rd_idx = r_cnt[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_pipe_vld <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_cnt <= '0;
            end else if (i_cmd.scan_issue) begin
                r_cnt <= r_cnt + 1'b1;
            end
            r_pipe_vld <= i_cmd.scan_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pipe_idx     <= rd_idx;
        r_pipe_ent_vld <= r_valid[rd_idx];
    end

    // compare stage: lowest valid match, lowest free slot
    logic                       r_found, r_free_found;
    logic [IDX_W-1:0]           r_found_idx, r_free_idx;
    logic [arpc_pkg::MAC_W-1:0] r_found_mac;
    logic                       match;

    assign match = r_pipe_ent_vld &&
                   (r_rd_data[ENTRY_W-1 -: arpc_pkg::IP_W] == r_target);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
        end else if (i_cmd.load) begin
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
        end else if (r_pipe_vld) begin
            if (match && !r_found) begin
                r_found <= 1'b1;
            end
            if (!r_pipe_ent_vld && !r_free_found) begin
                r_free_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pipe_vld && match && !r_found) begin
            r_found_idx <= r_pipe_idx;
            r_found_mac <= r_rd_data[arpc_pkg::MAC_W-1:0];
        end
        if (r_pipe_vld && !r_pipe_ent_vld && !r_free_found) begin
            r_free_idx <= r_pipe_idx;
        end
    end

    // learn slot: known entry, else first free, else entry 0
    logic [IDX_W-1:0] wr_idx;

    always_comb begin
        if (r_found) begin
            wr_idx = r_found_idx;
        end else if (r_free_found) begin
            wr_idx = r_free_idx;
        end else begin
            wr_idx = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write_entry) begin
            mem[wr_idx] <= {r_target, r_mac};
        end
        r_rd_data <= mem[rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.write_entry) begin
            r_valid[wr_idx] <= 1'b1;
        end
    end

    // output register
    logic                r_out_vld;
    arpc_pkg::t_out_item r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.hit          <= r_found;
            r_out.resolved_mac <= r_found ? r_found_mac : '0;
            r_out.send_request <= !r_found;
            r_out.target_ip    <= r_target;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    assign o_stat.is_resolve = (r_command == arpc_pkg::CMD_RESOLVE);
    assign o_stat.scan_last  = (r_cnt == LAST_CNT);
    assign o_stat.out_free   = !r_out_vld || i_out_ready;

endmodule

// ----- rtl/arp_cache_resolver.sv -----
// arp cache resolver top level: controller plus datapath
// flow: after acceptance the scan reads every entry in turn, then the last compare,
// then write or result, then the idle state; the scan reads one entry per cycle,
// and a new beat is taken only once the controller is back in idle
// a learn beat goes through write and gives no result; a stalled result holds off input
// reset clears all valid bits, control state and loads the default configuration
`timescale 1ns / 1ps

module arp_cache_resolver #(
    parameter int CACHE_ENTRIES = arpc_pkg::CACHE_ENTRIES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [arpc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [arpc_pkg::IP_W-1:0]      i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  arpc_pkg::t_in_item             i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output arpc_pkg::t_out_item            o_out_data
);

    arpc_pkg::t_dp_cmd  dp_cmd;
    arpc_pkg::t_dp_stat dp_stat;

    arpc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    arpc_datapath #(
        .CACHE_ENTRIES (CACHE_ENTRIES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat)
    );

endmodule

// ----- tb/arp_cache_resolver_test.sv -----
// testbench for the arp cache resolver: directed and random learn/resolve traffic
`timescale 1ns / 1ps

module arp_cache_resolver_test;

    localparam int ENTRIES    = arpc_pkg::CACHE_ENTRIES_DEF;
    localparam int LATENCY    = ENTRIES + 2;
    localparam int MAX_CYCLES = 400000;
    localparam int POOL_SIZE  = 12;
    localparam logic [arpc_pkg::CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [arpc_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [arpc_pkg::IP_W-1:0]      i_cfg_data;
    logic                           i_in_valid;
    logic                           o_in_ready;
    arpc_pkg::t_in_item             i_in_data;
    logic                           o_out_valid;
    logic                           i_out_ready;
    arpc_pkg::t_out_item            o_out_data;

    // shadow copy of the cache and its registers
    logic                       cache_valid [ENTRIES];
    logic [arpc_pkg::IP_W-1:0]  cache_ip    [ENTRIES];
    logic [arpc_pkg::MAC_W-1:0] cache_mac   [ENTRIES];
    logic [arpc_pkg::IP_W-1:0]  own_ip;
    logic [arpc_pkg::IP_W-1:0]  gateway_ip;
    logic [arpc_pkg::IP_W-1:0]  subnet_mask;

    arpc_pkg::t_out_item       answers_due[$];
    logic [arpc_pkg::IP_W-1:0] ip_pool [POOL_SIZE];
    int                        mismatches = 0;
    int                        gap_pct = 0;
    int                        stall_pct = 0;

    arp_cache_resolver #(.CACHE_ENTRIES(ENTRIES)) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        repeat (MAX_CYCLES) @(posedge i_clk);
        $display("arp_cache_resolver_test: errors");
        $finish;
    end

    function automatic int find_slot(logic [arpc_pkg::IP_W-1:0] ip);
        for (int k = 0; k < ENTRIES; k++)
            if (cache_valid[k] && cache_ip[k] == ip) return k;
        return -1;
    endfunction

    function automatic void learn_mapping(logic [arpc_pkg::IP_W-1:0] ip,
                                          logic [arpc_pkg::MAC_W-1:0] mac);
        int slot;
        slot = find_slot(ip);
        // lowest free entry, else entry 0 gets replaced
        if (slot < 0)
            for (int k = ENTRIES - 1; k >= 0; k--)
                if (!cache_valid[k]) slot = k;
        if (slot < 0) slot = 0;
        cache_valid[slot] = 1'b1;
        cache_ip[slot]    = ip;
        cache_mac[slot]   = mac;
    endfunction

    function automatic arpc_pkg::t_out_item next_hop_answer(logic [arpc_pkg::IP_W-1:0] dest);
        arpc_pkg::t_out_item ans;
        int                  slot;
        ans.target_ip    = (((dest ^ own_ip) & subnet_mask) != '0) ? gateway_ip : dest;
        slot             = find_slot(ans.target_ip);
        ans.hit          = (slot >= 0);
        ans.send_request = (slot < 0);
        ans.resolved_mac = (slot >= 0) ? cache_mac[slot] : '0;
        return ans;
    endfunction

    function automatic logic [arpc_pkg::MAC_W-1:0] rand_mac();
        return {16'($urandom_range(0, 65535)), 32'($urandom)};
    endfunction

    task automatic send_item(input logic cmd, input logic [arpc_pkg::IP_W-1:0] ip,
                             input logic [arpc_pkg::MAC_W-1:0] mac);
        arpc_pkg::t_in_item beat;
        int                 gap;
        beat.command  = cmd;
        beat.ip_addr  = ip;
        beat.mac_addr = mac;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (cmd == arpc_pkg::CMD_LEARN) learn_mapping(ip, mac);
        else answers_due.push_back(next_hop_answer(ip));
        if ($urandom_range(0, 99) < gap_pct) begin
            gap = $urandom_range(1, 13);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
    endtask

    // a trailing learn may still be busy after the last result
    task automatic settle_block();
        drain_results();
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [arpc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [arpc_pkg::IP_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            arpc_pkg::CFG_OWN_IP:      own_ip      = val;
            arpc_pkg::CFG_GATEWAY_IP:  gateway_ip  = val;
            arpc_pkg::CFG_SUBNET_MASK: subnet_mask = val;
            default: ;
        endcase
    endtask

    task automatic test_empty_cache();
        gap_pct   = 20;
        stall_pct = 5;
        send_item(arpc_pkg::CMD_RESOLVE, 32'h0A00_0263, rand_mac());
        send_item(arpc_pkg::CMD_RESOLVE, 32'h0808_0808, '0);
    endtask

    task automatic test_learn_and_replace();
        send_item(arpc_pkg::CMD_LEARN, arpc_pkg::GATEWAY_IP_RST, '1);
        send_item(arpc_pkg::CMD_RESOLVE, 32'h0808_0808, '1);
        send_item(arpc_pkg::CMD_LEARN, 32'h0A00_0214, '0);
        send_item(arpc_pkg::CMD_LEARN, 32'h0000_0000, rand_mac());
        send_item(arpc_pkg::CMD_LEARN, 32'hFFFF_FFFF, rand_mac());
        for (int k = 0; k < 4; k++)
            send_item(arpc_pkg::CMD_LEARN, 32'h0A00_0215 + k, rand_mac());
        // table full: known address updates in place
        send_item(arpc_pkg::CMD_LEARN, arpc_pkg::GATEWAY_IP_RST, 48'h0123_4567_89AB);
        send_item(arpc_pkg::CMD_RESOLVE, 32'h0808_0808, '0);
        // new address evicts entry 0, which held the gateway
        send_item(arpc_pkg::CMD_LEARN, 32'h0A00_021E, rand_mac());
        send_item(arpc_pkg::CMD_RESOLVE, 32'h0102_0304, rand_mac());
        send_item(arpc_pkg::CMD_RESOLVE, 32'h0A00_021E, '0);
        send_item(arpc_pkg::CMD_RESOLVE, 32'h0A00_0215, '0);
    endtask

    task automatic test_register_extremes();
        settle_block();
        // zero mask puts every destination on-link
        write_reg(arpc_pkg::CFG_SUBNET_MASK, '0);
        send_item(arpc_pkg::CMD_RESOLVE, 32'h0000_0000, rand_mac());
        send_item(arpc_pkg::CMD_RESOLVE, 32'hFFFF_FFFF, rand_mac());
        settle_block();
        write_reg(CFG_NO_REG, '0);
        send_item(arpc_pkg::CMD_RESOLVE, 32'h0A00_0214, rand_mac());
        settle_block();
        write_reg(arpc_pkg::CFG_SUBNET_MASK, '1);
        write_reg(arpc_pkg::CFG_OWN_IP, '1);
        write_reg(arpc_pkg::CFG_GATEWAY_IP, '0);
        send_item(arpc_pkg::CMD_RESOLVE, 32'hFFFF_FFFF, rand_mac());
        send_item(arpc_pkg::CMD_RESOLVE, 32'h0A00_0214, rand_mac());
        settle_block();
        write_reg(arpc_pkg::CFG_OWN_IP, '0);
        write_reg(arpc_pkg::CFG_GATEWAY_IP, '1);
        send_item(arpc_pkg::CMD_RESOLVE, 32'h0000_0000, rand_mac());
        send_item(arpc_pkg::CMD_RESOLVE, 32'h0000_0005, rand_mac());
    endtask

    task automatic pick_network(input int prefix, input logic keep_gw_local);
        logic [arpc_pkg::IP_W-1:0] mask;
        logic [arpc_pkg::IP_W-1:0] host;
        mask = (prefix == 0) ? '0 : ('1 << (32 - prefix));
        host = $urandom;
        settle_block();
        write_reg(arpc_pkg::CFG_SUBNET_MASK, mask);
        write_reg(arpc_pkg::CFG_OWN_IP, host);
        write_reg(arpc_pkg::CFG_GATEWAY_IP,
                  keep_gw_local ? ((host & mask) | ($urandom & ~mask)) : $urandom);
        ip_pool[0] = gateway_ip;
        for (int k = 1; k < POOL_SIZE; k++)
            ip_pool[k] = (own_ip & subnet_mask) | ($urandom & ~subnet_mask);
    endtask

    task automatic mixed_traffic(input int count, input int pause_at);
        int                        r;
        logic [arpc_pkg::IP_W-1:0] dest;
        for (int n = 0; n < count; n++) begin
            if (n == pause_at) drain_results();
            r = $urandom_range(0, 99);
            if (r < 45) begin
                dest = ($urandom_range(0, 99) < 85) ? ip_pool[$urandom_range(0, POOL_SIZE - 1)]
                                                    : $urandom;
                send_item(arpc_pkg::CMD_LEARN, dest, rand_mac());
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60)      dest = ip_pool[$urandom_range(0, POOL_SIZE - 1)];
                else if (r < 75) dest = gateway_ip;
                else             dest = $urandom;
                send_item(arpc_pkg::CMD_RESOLVE, dest, rand_mac());
            end
        end
    endtask

    task automatic test_random_traffic();
        int prefix;
        for (int phase = 0; phase < 6; phase++) begin
            if (phase == 0) begin
                settle_block();
                write_reg(arpc_pkg::CFG_OWN_IP, arpc_pkg::OWN_IP_RST);
                write_reg(arpc_pkg::CFG_GATEWAY_IP, arpc_pkg::GATEWAY_IP_RST);
                write_reg(arpc_pkg::CFG_SUBNET_MASK, arpc_pkg::SUBNET_MASK_RST);
                ip_pool[0] = gateway_ip;
                for (int k = 1; k < POOL_SIZE; k++)
                    ip_pool[k] = (own_ip & subnet_mask) | 32'($urandom_range(0, 20));
            end else begin
                prefix = (phase == 1) ? 32 : (phase == 2) ? 0 : $urandom_range(8, 30);
                pick_network(prefix, phase != 5);
            end
            // phase 1 runs with no idling on either side
            gap_pct   = (phase == 1) ? 0 : $urandom_range(10, 50);
            stall_pct = (phase == 1) ? 0 : $urandom_range(2, 15);
            mixed_traffic(160, (phase == 2) ? 80 : -1);
        end
    endtask

    task automatic test_steady_stream();
        pick_network($urandom_range(16, 28), 1'b1);
        gap_pct   = 0;
        stall_pct = 0;
        mixed_traffic(140, -1);
    endtask

    initial begin : result_ready_gen
        int stall;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 99) < stall_pct) begin
                stall = $urandom_range(1, 13);
                i_out_ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        arpc_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (answers_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result beat with nothing pending: %p", o_out_data);
            end else begin
                want = answers_due.pop_front();
                if (o_out_data.hit !== want.hit ||
                    o_out_data.resolved_mac !== want.resolved_mac ||
                    o_out_data.send_request !== want.send_request ||
                    o_out_data.target_ip !== want.target_ip) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp/got: hit %0b/%0b mac %h/%h req %0b/%0b tgt %h/%h",
                                 want.hit, o_out_data.hit,
                                 want.resolved_mac, o_out_data.resolved_mac,
                                 want.send_request, o_out_data.send_request,
                                 want.target_ip, o_out_data.target_ip);
                end
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = arpc_pkg::CFG_OWN_IP;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        own_ip      = arpc_pkg::OWN_IP_RST;
        gateway_ip  = arpc_pkg::GATEWAY_IP_RST;
        subnet_mask = arpc_pkg::SUBNET_MASK_RST;
        for (int k = 0; k < ENTRIES; k++) begin
            cache_valid[k] = 1'b0;
            cache_ip[k]    = '0;
            cache_mac[k]   = '0;
        end
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_cache();
        test_learn_and_replace();
        test_register_extremes();
        test_random_traffic();
        test_steady_stream();

        drain_results();
        repeat (2 * LATENCY) @(posedge i_clk);
        if (mismatches == 0 && answers_due.size() == 0)
            $display("arp_cache_resolver_test: clean");
        else
            $display("arp_cache_resolver_test: errors");
        $finish;
    end

endmodule

// ----- arp_cache_resolver.f -----
rtl/arpc_pkg.sv
rtl/arpc_ctrl.sv
rtl/arpc_datapath.sv
rtl/arp_cache_resolver.sv
tb/arp_cache_resolver_test.sv
